// File: rtl/dmp_pkg.sv
// shared types and constants for the dhcp message parser
// no dependencies; imported by the step logic, the top level and the checker
package dmp_pkg;

    // parse phases of the datagram walker
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CODE    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_END     = 3'd4,
        PH_FULL    = 3'd5
    } phase_t;

    // kinds of result beat
    typedef enum logic [2:0] {
        KIND_NUMBER    = 3'd0,
        KIND_ARRAY     = 3'd1,
        KIND_OPT_HDR   = 3'd2,
        KIND_OPT_DATA  = 3'd3,
        KIND_END_OPT   = 3'd4,
        KIND_DGRAM_END = 3'd5
    } item_kind_t;

    // field identifiers of the fixed header arrays
    localparam logic [3:0] FID_CHADDR = 4'd11;
    localparam logic [3:0] FID_SNAME  = 4'd12;
    localparam logic [3:0] FID_FILE   = 4'd13;

    // header layout
    localparam logic [7:0] POS_CHADDR    = 8'd28;
    localparam logic [7:0] POS_SNAME     = 8'd44;
    localparam logic [7:0] POS_FILE      = 8'd108;
    localparam logic [7:0] POS_COOKIE    = 8'd236;
    localparam logic [7:0] POS_LAST_HDR  = 8'd239;

    localparam logic [7:0] OPT_PAD = 8'h00;
    localparam logic [7:0] OPT_END = 8'hff;

    typedef struct packed {
        logic [7:0]  byte_pos;
        logic [31:0] accum;
        phase_t      phase;
        logic [7:0]  code;
        logic [7:0]  length;
        logic [7:0]  index;
        logic [6:0]  taken;
    } dmp_state_t;

    localparam dmp_state_t STATE_RESET = '{
        byte_pos: 8'd0,
        accum:    32'd0,
        phase:    PH_HEADER,
        code:     8'd0,
        length:   8'd0,
        index:    8'd0,
        taken:    7'd0
    };

    typedef struct packed {
        item_kind_t  kind;
        logic [3:0]  field_id;
        logic [31:0] field_value;
        logic [7:0]  option_code;
        logic [7:0]  option_length;
        logic [7:0]  byte_index;
        logic [6:0]  option_count;
        logic        end_seen;
        logic        frame_end;
    } dmp_result_t;

    // which fixed header number a byte position belongs to (positions below 28)
    function automatic logic [3:0] number_id(input logic [7:0] p);
        logic [3:0] id;
        case (p) inside
            [8'd0:8'd3]:   id = p[3:0];
            [8'd4:8'd7]:   id = 4'd4;
            [8'd8:8'd9]:   id = 4'd5;
            [8'd10:8'd11]: id = 4'd6;
            [8'd12:8'd15]: id = 4'd7;
            [8'd16:8'd19]: id = 4'd8;
            [8'd20:8'd23]: id = 4'd9;
            default:       id = 4'd10;
        endcase
        return id;
    endfunction

    // first byte of a header number
    function automatic logic number_start(input logic [7:0] p);
        logic s;
        case (p) inside
            8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd10,
            8'd12, 8'd16, 8'd20, 8'd24: s = 1'b1;
            default:                    s = 1'b0;
        endcase
        return s;
    endfunction

    // last byte of a header number
    function automatic logic number_last(input logic [7:0] p);
        logic e;
        case (p) inside
            8'd0, 8'd1, 8'd2, 8'd3, 8'd7, 8'd9, 8'd11,
            8'd15, 8'd19, 8'd23, 8'd27: e = 1'b1;
            default:                    e = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// File: rtl/dmp_step.sv
// per-byte parse step: next parser state and the result beat for one byte
// depends on dmp_pkg
module dmp_step #(
    parameter int MAX_OPTIONS = 64
) (
    input  dmp_pkg::dmp_state_t  state_q,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output dmp_pkg::dmp_state_t  state_d,
    output dmp_pkg::dmp_result_t result,
    output logic                 emit
);
    import dmp_pkg::*;

    logic [7:0]  pos;
    logic [6:0]  taken_inc;
    logic        limit_hit;
    logic [7:0]  index_inc;
    logic [31:0] accum_new;
    dmp_state_t  upd;

    assign pos       = state_q.byte_pos;
    assign taken_inc = state_q.taken + 7'd1;
    assign limit_hit = (taken_inc >= 7'(MAX_OPTIONS));
    assign index_inc = state_q.index + 8'd1;
    assign accum_new = number_start(pos) ? {24'd0, data_byte}
                                         : {state_q.accum[23:0], data_byte};

    // next state
    always_comb begin
        upd = state_q;
        case (state_q.phase)
            PH_HEADER: begin
                if (pos < POS_CHADDR) begin
                    upd.accum = accum_new;
                end
                if (pos >= POS_LAST_HDR) begin
                    upd.phase = PH_CODE;
                end else begin
                    upd.byte_pos = pos + 8'd1;
                end
            end
            PH_CODE: begin
                if (data_byte == OPT_END) begin
                    upd.phase = PH_END;
                end else if (data_byte != OPT_PAD) begin
                    upd.code  = data_byte;
                    upd.phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                upd.length = data_byte;
                upd.index  = 8'd0;
                if (data_byte == 8'd0) begin
                    upd.taken = taken_inc;
                    upd.phase = limit_hit ? PH_FULL : PH_CODE;
                end else begin
                    upd.phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                upd.index = index_inc;
                if (index_inc >= state_q.length) begin
                    upd.taken = taken_inc;
                    upd.phase = limit_hit ? PH_FULL : PH_CODE;
                end
            end
            default: ;
        endcase
        state_d = last_byte ? STATE_RESET : upd;
    end

    // result beat
    always_comb begin
        logic hit;
        hit    = 1'b0;
        result = '{
            kind:          KIND_DGRAM_END,
            field_id:      4'd0,
            field_value:   32'd0,
            option_code:   8'd0,
            option_length: 8'd0,
            byte_index:    8'd0,
            option_count:  upd.taken,
            end_seen:      (upd.phase == PH_END),
            frame_end:     last_byte
        };
        case (state_q.phase)
            PH_HEADER: begin
                if (pos < POS_CHADDR) begin
                    if (number_last(pos)) begin
                        hit                = 1'b1;
                        result.kind        = KIND_NUMBER;
                        result.field_id    = number_id(pos);
                        result.field_value = accum_new;
                    end
                end else if (pos < POS_COOKIE) begin
                    hit                = 1'b1;
                    result.kind        = KIND_ARRAY;
                    result.field_value = {24'd0, data_byte};
                    if (pos < POS_SNAME) begin
                        result.field_id   = FID_CHADDR;
                        result.byte_index = pos - POS_CHADDR;
                    end else if (pos < POS_FILE) begin
                        result.field_id   = FID_SNAME;
                        result.byte_index = pos - POS_SNAME;
                    end else begin
                        result.field_id   = FID_FILE;
                        result.byte_index = pos - POS_FILE;
                    end
                end
            end
            PH_CODE: begin
                if (data_byte == OPT_END) begin
                    hit                = 1'b1;
                    result.kind        = KIND_END_OPT;
                    result.option_code = OPT_END;
                end
            end
            PH_LENGTH: begin
                hit                  = 1'b1;
                result.kind          = KIND_OPT_HDR;
                result.option_code   = state_q.code;
                result.option_length = data_byte;
            end
            PH_PAYLOAD: begin
                hit                  = 1'b1;
                result.kind          = KIND_OPT_DATA;
                result.option_code   = state_q.code;
                result.option_length = state_q.length;
                result.field_value   = {24'd0, data_byte};
                result.byte_index    = state_q.index;
            end
            default: ;
        endcase
        emit = hit || last_byte;
    end

endmodule

// File: rtl/dhcp_message_parser.sv
// dhcp message parser top level: parser state, result register, handshakes
// depends on dmp_pkg and dmp_step
//
//   channel  | dir | handshake           | payload
//   s_       | in  | s_valid / s_ready   | s_data_byte, s_last_byte
//   m_       | out | m_valid / m_ready   | m_item_kind .. m_frame_end
//
// one byte is taken per cycle, back to back, unless a result beat is stalled;
// the whole parse step sits between the parser state registers and the result register
// a result shows on m_ in the cycle after its byte is accepted
// s_ready is high whenever the result register is empty or being taken
// synchronous active-low reset clears the parser state and m_valid
// while a result beat is stalled no byte is taken, even one that gives
// no result, so ordering is kept
module dhcp_message_parser #(
    parameter int MAX_OPTIONS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_item_kind,
    output logic [3:0] m_field_id,
    output logic [31:0] m_field_value,
    output logic [7:0] m_option_code,
    output logic [7:0] m_option_length,
    output logic [7:0] m_byte_index,
    output logic [6:0] m_option_count,
    output logic       m_end_seen,
    output logic       m_frame_end
);
    import dmp_pkg::*;

    dmp_state_t  state_reg, state_next;
    dmp_result_t result_reg, result_next;
    logic        valid_reg;
    logic        emit;
    logic        accept;

    // parse step
    dmp_step #(
        .MAX_OPTIONS(MAX_OPTIONS)
    ) u_step (
        .state_q   (state_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .state_d   (state_next),
        .result    (result_next),
        .emit      (emit)
    );

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_item_kind     = result_reg.kind;
    assign m_field_id      = result_reg.field_id;
    assign m_field_value   = result_reg.field_value;
    assign m_option_code   = result_reg.option_code;
    assign m_option_length = result_reg.option_length;
    assign m_byte_index    = result_reg.byte_index;
    assign m_option_count  = result_reg.option_count;
    assign m_end_seen      = result_reg.end_seen;
    assign m_frame_end     = result_reg.frame_end;

endmodule

// File: rtl/dmp_checker.sv
// port-level checks for the dhcp message parser, bound to the top level
// depends on dmp_pkg and dhcp_message_parser
module dmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_item_kind,
    input logic [31:0] m_field_value,
    input logic [7:0]  m_option_code,
    input logic        m_end_seen,
    input logic        m_frame_end
);
    import dmp_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_value))
        else $error("stalled result changed");

    // an empty output never blocks input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // a datagram-end-only beat is always the last of its datagram
    a_dgram_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_DGRAM_END) |-> m_frame_end)
        else $error("datagram end beat without frame_end");

    // the end option sets end_seen and carries its code
    a_end_opt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_END_OPT) |-> m_end_seen && (m_option_code == OPT_END))
        else $error("end option beat inconsistent");

endmodule

bind dhcp_message_parser dmp_checker u_dmp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_item_kind    (m_item_kind),
    .m_field_value  (m_field_value),
    .m_option_code  (m_option_code),
    .m_end_seen     (m_end_seen),
    .m_frame_end    (m_frame_end)
);

// File: test/dhcp_message_parser_test.sv
// self-checking testbench for dhcp_message_parser: directed datagrams, then random ones
// depends on dmp_pkg and the parser rtl; a local byte-walker predicts each result beat
`timescale 1ns / 1ps

module dhcp_message_parser_test;
    import dmp_pkg::*;

    localparam int OPTION_LIMIT = 64;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;
    localparam logic [3:0] FID_OP = 4'd0;

    // one line of the directed stimulus table
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int          reps;
        bit          zero_pair;
        bit          known;
        dmp_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_item_kind;
    logic [3:0]  m_field_id;
    logic [31:0] m_field_value;
    logic [7:0]  m_option_code;
    logic [7:0]  m_option_length;
    logic [7:0]  m_byte_index;
    logic [6:0]  m_option_count;
    logic        m_end_seen;
    logic        m_frame_end;

    // predictor copy of the parser state
    logic [10:0] hdr_pos;
    logic [31:0] number_acc;
    phase_t      walk_phase;
    logic [7:0]  opt_code;
    logic [7:0]  opt_len;
    logic [7:0]  pay_idx;
    logic [6:0]  opt_taken;

    dmp_result_t expected_q[$];
    stim_row_t   stim_table[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches = 0;
    int          sent_items = 0;
    int          idle_cycles = 0;
    bit          send_burst = 1'b0;
    bit          ready_burst = 1'b0;
    int          ready_hold = 0;

    dhcp_message_parser #(
        .MAX_OPTIONS(OPTION_LIMIT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_field_id      (m_field_id),
        .m_field_value   (m_field_value),
        .m_option_code   (m_option_code),
        .m_option_length (m_option_length),
        .m_byte_index    (m_byte_index),
        .m_option_count  (m_option_count),
        .m_end_seen      (m_end_seen),
        .m_frame_end     (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // which fixed header number a position belongs to
    function automatic logic [3:0] header_field_of(input logic [10:0] p);
        if (p < 4) return p[3:0];
        if (p < 8) return 4'd4;
        if (p < 10) return 4'd5;
        if (p < 12) return 4'd6;
        return 4'(7 + (p - 12) / 4);
    endfunction

    task automatic clear_walker();
        hdr_pos    = '0;
        number_acc = '0;
        walk_phase = PH_HEADER;
        opt_code   = '0;
        opt_len    = '0;
        pay_idx    = '0;
        opt_taken  = '0;
    endtask

    task automatic take_option();
        opt_taken = opt_taken + 7'd1;
        if (opt_taken >= OPTION_LIMIT) begin
            walk_phase = PH_FULL;
        end else begin
            walk_phase = PH_CODE;
        end
    endtask

    // advance the walker by one byte and queue the beat it should produce
    task automatic predict_byte(input logic [7:0] b, input logic last);
        dmp_result_t r;
        bit          emit;
        logic [10:0] p;
        logic [3:0]  id;
        r = '0;
        r.kind = KIND_DGRAM_END;
        emit = 1'b0;
        p = hdr_pos;
        case (walk_phase)
            PH_HEADER: begin
                if (p < POS_CHADDR) begin
                    id = header_field_of(p);
                    if (p == 0 || header_field_of(p - 11'd1) != id) begin
                        number_acc = {24'd0, b};
                    end else begin
                        number_acc = {number_acc[23:0], b};
                    end
                    if (p == POS_CHADDR - 1 || header_field_of(p + 11'd1) != id) begin
                        emit = 1'b1;
                        r.kind = KIND_NUMBER;
                        r.field_id = id;
                        r.field_value = number_acc;
                    end
                end else if (p < POS_SNAME) begin
                    emit = 1'b1;
                    r.kind = KIND_ARRAY;
                    r.field_id = FID_CHADDR;
                    r.field_value = {24'd0, b};
                    r.byte_index = 8'(p - POS_CHADDR);
                end else if (p < POS_FILE) begin
                    emit = 1'b1;
                    r.kind = KIND_ARRAY;
                    r.field_id = FID_SNAME;
                    r.field_value = {24'd0, b};
                    r.byte_index = 8'(p - POS_SNAME);
                end else if (p < POS_COOKIE) begin
                    emit = 1'b1;
                    r.kind = KIND_ARRAY;
                    r.field_id = FID_FILE;
                    r.field_value = {24'd0, b};
                    r.byte_index = 8'(p - POS_FILE);
                end
                if (p >= POS_LAST_HDR) begin
                    walk_phase = PH_CODE;
                end else begin
                    hdr_pos = p + 11'd1;
                end
            end
            PH_CODE: begin
                if (b == OPT_END) begin
                    emit = 1'b1;
                    r.kind = KIND_END_OPT;
                    r.option_code = OPT_END;
                    walk_phase = PH_END;
                end else if (b != OPT_PAD) begin
                    opt_code = b;
                    walk_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                opt_len = b;
                pay_idx = '0;
                emit = 1'b1;
                r.kind = KIND_OPT_HDR;
                r.option_code = opt_code;
                r.option_length = b;
                if (b == 8'd0) begin
                    take_option();
                end else begin
                    walk_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                emit = 1'b1;
                r.kind = KIND_OPT_DATA;
                r.option_code = opt_code;
                r.option_length = opt_len;
                r.field_value = {24'd0, b};
                r.byte_index = pay_idx;
                pay_idx = pay_idx + 8'd1;
                if (pay_idx >= opt_len) take_option();
            end
            default: begin
            end
        endcase
        if (emit || last) begin
            r.option_count = opt_taken;
            r.end_seen = (walk_phase == PH_END);
            r.frame_end = last;
            expected_q.push_back(r);
        end
        if (last) clear_walker();
    endtask

    // offer one beat, wait for it to be taken, then predict it
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        predict_byte(d, last);
        sent_items++;
    endtask

    // hold the input off until every queued result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic add_bytes(input logic [7:0] d, input logic last, input int reps,
                             input bit zero_pair);
        stim_row_t row;
        row = '{data: d, last: last, reps: reps, zero_pair: zero_pair, known: 1'b0,
                want: '0};
        stim_table.push_back(row);
    endtask

    task automatic add_known(input logic [7:0] d, input logic last, input item_kind_t kind,
                             input logic [3:0] fid, input logic [31:0] fval,
                             input logic [7:0] code, input logic [6:0] count,
                             input logic ended);
        stim_row_t row;
        row = '{data: d, last: last, reps: 1, zero_pair: 1'b0, known: 1'b1, want: '0};
        row.want.kind = kind;
        row.want.field_id = fid;
        row.want.field_value = fval;
        row.want.option_code = code;
        row.want.option_count = count;
        row.want.end_seen = ended;
        row.want.frame_end = last;
        stim_table.push_back(row);
    endtask

    // random datagram: mostly well formed, some cut short, some plain noise
    task automatic build_frame();
        int style;
        int n_opts;
        int len;
        int cut;
        int r;
        bit many;
        frame_bytes.delete();
        style = $urandom_range(0, 99);
        if (style >= 80) begin
            len = $urandom_range(1, 60);
            repeat (len) frame_bytes.push_back(8'($urandom));
            return;
        end
        repeat (POS_COOKIE) frame_bytes.push_back(8'($urandom));
        // magic cookie, occasionally garbage since it is never checked
        if ($urandom_range(0, 9) == 0) begin
            repeat (4) frame_bytes.push_back(8'($urandom));
        end else begin
            frame_bytes.push_back(8'h63);
            frame_bytes.push_back(8'h82);
            frame_bytes.push_back(8'h53);
            frame_bytes.push_back(8'h63);
        end
        many = ($urandom_range(0, 11) == 0);
        n_opts = many ? $urandom_range(OPTION_LIMIT - 4, OPTION_LIMIT + 6)
                      : $urandom_range(0, 10);
        repeat (n_opts) begin
            if ($urandom_range(0, 7) == 0) frame_bytes.push_back(OPT_PAD);
            frame_bytes.push_back(8'($urandom_range(1, 254)));
            r = $urandom_range(0, 99);
            if (many) len = $urandom_range(0, 2);
            else if (r < 80) len = $urandom_range(0, 6);
            else if (r < 95) len = $urandom_range(7, 40);
            else len = $urandom_range(41, 255);
            frame_bytes.push_back(8'(len));
            repeat (len) frame_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 85) begin
            frame_bytes.push_back(OPT_END);
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
        end
        if (style >= 55) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch({"mismatch on ", name}, got, want);
    endtask

    // result side pacing with random stalls and stall-free stretches
    always @(posedge aclk) begin : sink_pacing
        int g;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            g = ready_burst ? 0 : pick_gap();
            ready_hold <= (g > 0) ? g - 1 : 0;
            m_ready <= (g == 0);
        end
        if ($urandom_range(0, 199) == 0) ready_burst <= !ready_burst;
    end

    // compare each taken result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        dmp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing expected, kind", 32'(m_item_kind),
                                32'd0);
            end else begin
                want = expected_q.pop_front();
                check_field("item_kind", 32'(m_item_kind), 32'(want.kind));
                check_field("field_id", 32'(m_field_id), 32'(want.field_id));
                check_field("field_value", m_field_value, want.field_value);
                check_field("option_code", 32'(m_option_code), 32'(want.option_code));
                check_field("option_length", 32'(m_option_length), 32'(want.option_length));
                check_field("byte_index", 32'(m_byte_index), 32'(want.byte_index));
                check_field("option_count", 32'(m_option_count), 32'(want.option_count));
                check_field("end_seen", 32'(m_end_seen), 32'(want.end_seen));
                check_field("frame_end", 32'(m_frame_end), 32'(want.frame_end));
            end
        end
    end

    // end the run if no beat moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int reps;
        // short datagrams that stop on the op byte, both byte extremes
        add_known(8'hff, 1'b1, KIND_NUMBER, FID_OP, 32'hff, 8'h00, 7'd0, 1'b0);
        add_known(8'h00, 1'b1, KIND_NUMBER, FID_OP, 32'h0, 8'h00, 7'd0, 1'b0);
        // datagram cut inside xid, last byte gives no number
        add_bytes(8'h12, 1'b0, 5, 1'b0);
        add_known(8'h34, 1'b1, KIND_DGRAM_END, 4'd0, 32'd0, 8'h00, 7'd0, 1'b0);
        // full datagram: header, pad, normal, empty and longest option, end, trailer
        add_bytes(8'h01, 1'b0, 2, 1'b0);
        add_bytes(8'h06, 1'b0, 1, 1'b0);
        add_bytes(8'h00, 1'b0, 1, 1'b0);
        add_bytes(8'hff, 1'b0, 4, 1'b0);
        add_bytes(8'h00, 1'b0, 4, 1'b0);
        add_bytes(8'ha5, 1'b0, 16, 1'b0);
        add_bytes(8'h5a, 1'b0, 208, 1'b0);
        add_bytes(8'h63, 1'b0, 4, 1'b0);
        add_bytes(OPT_PAD, 1'b0, 1, 1'b0);
        add_bytes(8'h35, 1'b0, 1, 1'b0);
        add_bytes(8'h01, 1'b0, 1, 1'b0);
        add_bytes(8'h05, 1'b0, 1, 1'b0);
        add_bytes(8'h50, 1'b0, 1, 1'b1);
        add_bytes(8'hfe, 1'b0, 1, 1'b0);
        add_bytes(8'hff, 1'b0, 1, 1'b0);
        add_bytes(8'h00, 1'b0, 255, 1'b0);
        add_known(OPT_END, 1'b0, KIND_END_OPT, 4'd0, 32'd0, OPT_END, 7'd3, 1'b1);
        add_bytes(8'h11, 1'b0, 3, 1'b0);
        add_known(8'h22, 1'b1, KIND_DGRAM_END, 4'd0, 32'd0, 8'h00, 7'd3, 1'b1);
        // datagram that ends on a cookie byte
        add_bytes(8'h00, 1'b0, 238, 1'b0);
        add_known(8'h63, 1'b1, KIND_DGRAM_END, 4'd0, 32'd0, 8'h00, 7'd0, 1'b0);
        // option limit reached by empty options, later bytes ignored
        add_bytes(8'h00, 1'b0, 240, 1'b0);
        add_bytes(8'h01, 1'b0, OPTION_LIMIT, 1'b1);
        add_bytes(8'h33, 1'b0, 2, 1'b0);
        add_known(OPT_END, 1'b1, KIND_DGRAM_END, 4'd0, 32'd0, 8'h00, 7'(OPTION_LIMIT),
                  1'b0);

        clear_walker();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (stim_table[i]) begin
            reps = stim_table[i].reps;
            for (int k = 0; k < reps; k++) begin
                send_byte(stim_table[i].data, stim_table[i].last && (k == reps - 1));
                if (stim_table[i].zero_pair) send_byte(8'h00, 1'b0);
            end
            if (stim_table[i].known) begin
                void'(expected_q.pop_back());
                expected_q.push_back(stim_table[i].want);
            end
        end
        drain_results();

        // random datagrams until the overall byte budget is used
        while (sent_items < TOTAL_ITEMS) begin
            build_frame();
            send_burst = ($urandom_range(0, 3) == 0);
            foreach (frame_bytes[j]) send_byte(frame_bytes[j], j == frame_bytes.size() - 1);
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
